// ===== rtl/core/vrbs_pkg.sv =====
// Shared constants, request and status codes, and the memory port type for the record stack.
package vrbs_pkg;

  localparam int STACK_BYTES      = 1024;
  localparam int MAX_RECORD_BYTES = 64;
  localparam int HEADER_BYTES     = 4;

  localparam int ADDR_W = $clog2(STACK_BYTES);
  localparam int TOP_W  = $clog2(STACK_BYTES + 1);
  localparam int LEN_W  = 7;
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int CNT_W  = $clog2(HEADER_BYTES + 1);
  localparam int SUM_W  = ((HDR_W > TOP_W) ? HDR_W : TOP_W) + 2;

  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic fits_fn(input logic [TOP_W-1:0] t, input logic [LEN_W-1:0] l);
    logic [TOP_W:0] need;
    need = (TOP_W + 1)'(l) + (TOP_W + 1)'(HEADER_BYTES);
    return (l <= LEN_W'(MAX_RECORD_BYTES)) && ({1'b0, t} >= need);
  endfunction

endpackage

// ===== rtl/core/vrbs_mem.sv =====
// Byte-wide stack memory with one write port and one registered read port.
module vrbs_mem (
  input  logic                clk,
  input  vrbs_pkg::mem_req_t  req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [vrbs_pkg::STACK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/core/vrbs_ctrl.sv =====
// Request sequencer: push runs, header write and read, byte emission, and result register.
module vrbs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      req_type,
  input  logic [7:0]                      data_byte,
  input  logic [vrbs_pkg::LEN_W-1:0]      item_len,
  input  logic                            last,
  output vrbs_pkg::mem_req_t              mreq,
  input  logic [7:0]                      rdata,
  output logic                            valid,
  output logic [1:0]                      status,
  output logic [7:0]                      out_byte,
  output logic                            byte_valid,
  output logic                            last_result,
  output logic                            is_empty,
  output logic                            fits
);

  localparam int TOP_W  = vrbs_pkg::TOP_W;
  localparam int LEN_W  = vrbs_pkg::LEN_W;
  localparam int HDR_W  = vrbs_pkg::HDR_W;
  localparam int CNT_W  = vrbs_pkg::CNT_W;
  localparam int SUM_W  = vrbs_pkg::SUM_W;
  localparam int ADDR_W = vrbs_pkg::ADDR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HWR  = 3'd1;
  localparam logic [2:0] S_HRD  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;

  logic [2:0]       state, state_next;
  logic [TOP_W-1:0] top, top_next;
  logic             push_open, push_open_next;
  logic             push_reject, push_reject_next;
  logic [TOP_W-1:0] push_base, push_base_next;
  logic [LEN_W-1:0] push_index, push_index_next;
  logic [LEN_W-1:0] push_len, push_len_next;
  logic [LEN_W-1:0] req_len, req_len_next;
  logic             is_pop, is_pop_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [HDR_W-1:0] hdr_val, hdr_val_next;
  logic [LEN_W-1:0] n_len, n_len_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [TOP_W:0]   rbase, rbase_next;
  logic             rd_oob, rd_oob_next;

  logic             emit;
  logic [1:0]       e_status;
  logic [7:0]       e_byte;
  logic             e_bv;
  logic             e_last;
  logic [LEN_W-1:0] len_src;

  logic [TOP_W-1:0] base_eff;
  logic             rej_eff;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] idx_eff;
  logic [TOP_W:0]   raddr_full;
  logic             rd_issue;
  logic [7:0]       rbyte;
  logic [HDR_W-1:0] hdr_shift;
  logic [SUM_W-1:0] pop_top;
  logic [LEN_W-1:0] n_min;
  logic [LEN_W-1:0] n_calc;
  logic [TOP_W-1:0] top_empty;

  assign busy      = (state != S_IDLE);
  assign top_empty = TOP_W'(vrbs_pkg::STACK_BYTES);
  assign base_eff  = push_open ? push_base : (top - TOP_W'(item_len));
  assign rej_eff   = push_open ? push_reject : !vrbs_pkg::fits_fn(top, item_len);
  assign len_eff   = push_open ? push_len : item_len;
  assign idx_eff   = push_open ? push_index : '0;
  assign rbyte     = rd_oob ? 8'h00 : rdata;
  assign hdr_shift = HDR_W'(rbyte) << {cnt - CNT_W'(1), 3'b000};
  assign pop_top   = SUM_W'(rbase) + SUM_W'(hdr_val);
  assign n_min     = (SUM_W'(hdr_val) < SUM_W'(req_len)) ? hdr_val[LEN_W-1:0] : req_len;
  assign n_calc    = (n_min > LEN_W'(vrbs_pkg::MAX_RECORD_BYTES)) ?
                     LEN_W'(vrbs_pkg::MAX_RECORD_BYTES) : n_min;

  always_comb begin
    state_next       = state;
    top_next         = top;
    push_open_next   = push_open;
    push_reject_next = push_reject;
    push_base_next   = push_base;
    push_index_next  = push_index;
    push_len_next    = push_len;
    req_len_next     = req_len;
    is_pop_next      = is_pop;
    cnt_next         = cnt;
    hdr_val_next     = hdr_val;
    n_len_next       = n_len;
    idx_next         = idx;
    rbase_next       = rbase;
    mreq             = '0;
    raddr_full       = '0;
    rd_issue         = 1'b0;
    emit             = 1'b0;
    e_status         = vrbs_pkg::ST_OK;
    e_byte           = 8'h00;
    e_bv             = 1'b0;
    e_last           = 1'b1;
    len_src          = req_len;
    case (state)
      S_IDLE: begin
        len_src = item_len;
        if (start) begin
          req_len_next = item_len;
          if (req_type == vrbs_pkg::REQ_PUSH) begin
            push_open_next   = 1'b1;
            push_len_next    = len_eff;
            push_reject_next = rej_eff;
            push_base_next   = base_eff;
            if (!rej_eff && (idx_eff < len_eff)) begin
              mreq.we    = 1'b1;
              mreq.waddr = ADDR_W'(base_eff + TOP_W'(idx_eff));
              mreq.wdata = data_byte;
            end
            push_index_next = (idx_eff == '1) ? idx_eff : idx_eff + LEN_W'(1);
            if (last) begin
              push_open_next   = 1'b0;
              push_reject_next = 1'b0;
              if (rej_eff) begin
                emit     = 1'b1;
                e_status = vrbs_pkg::ST_FULL;
              end else begin
                cnt_next   = '0;
                state_next = S_HWR;
              end
            end
          end else begin
            push_open_next   = 1'b0;
            push_reject_next = 1'b0;
            if (req_type == vrbs_pkg::REQ_POP || req_type == vrbs_pkg::REQ_PEEK) begin
              is_pop_next = (req_type == vrbs_pkg::REQ_POP);
              if (top >= top_empty) begin
                emit     = 1'b1;
                e_status = vrbs_pkg::ST_EMPTY;
              end else begin
                cnt_next     = '0;
                hdr_val_next = '0;
                state_next   = S_HRD;
              end
            end else begin
              if (req_type == vrbs_pkg::REQ_CLEAR) begin
                top_next = top_empty;
              end
              emit = 1'b1;
            end
          end
        end
      end
      S_HWR: begin
        mreq.we    = 1'b1;
        mreq.waddr = ADDR_W'(push_base - TOP_W'(vrbs_pkg::HEADER_BYTES) + TOP_W'(cnt));
        mreq.wdata = (cnt == '0) ? 8'(push_len) : 8'h00;
        if (cnt == CNT_W'(vrbs_pkg::HEADER_BYTES - 1)) begin
          top_next   = push_base - TOP_W'(vrbs_pkg::HEADER_BYTES);
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_HRD: begin
        if (cnt < CNT_W'(vrbs_pkg::HEADER_BYTES)) begin
          rd_issue   = 1'b1;
          raddr_full = {1'b0, top} + (TOP_W + 1)'(cnt);
        end
        if (cnt != '0) begin
          hdr_val_next = hdr_val | hdr_shift;
        end
        if (cnt == CNT_W'(vrbs_pkg::HEADER_BYTES)) begin
          rbase_next = {1'b0, top} + (TOP_W + 1)'(vrbs_pkg::HEADER_BYTES);
          state_next = S_CALC;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_CALC: begin
        n_len_next = n_calc;
        idx_next   = '0;
        if (is_pop) begin
          top_next = (pop_top > SUM_W'(vrbs_pkg::STACK_BYTES)) ? top_empty :
                     pop_top[TOP_W-1:0];
        end
        if (n_calc == '0) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        if (idx < n_len) begin
          rd_issue   = 1'b1;
          raddr_full = rbase + (TOP_W + 1)'(idx);
        end
        if (idx != '0) begin
          emit   = 1'b1;
          e_byte = rbyte;
          e_bv   = 1'b1;
          e_last = (idx == n_len);
        end
        if (idx == n_len) begin
          state_next = S_IDLE;
        end
        idx_next = idx + LEN_W'(1);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    mreq.raddr  = ADDR_W'(raddr_full);
    rd_oob_next = rd_issue && (raddr_full >= (TOP_W + 1)'(vrbs_pkg::STACK_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      top         <= TOP_W'(vrbs_pkg::STACK_BYTES);
      push_open   <= 1'b0;
      push_reject <= 1'b0;
      push_base   <= '0;
      push_index  <= '0;
      valid       <= 1'b0;
    end else begin
      state       <= state_next;
      top         <= top_next;
      push_open   <= push_open_next;
      push_reject <= push_reject_next;
      push_base   <= push_base_next;
      push_index  <= push_index_next;
      valid       <= emit;
    end
  end

  always_ff @(posedge clk) begin
    push_len    <= push_len_next;
    req_len     <= req_len_next;
    is_pop      <= is_pop_next;
    cnt         <= cnt_next;
    hdr_val     <= hdr_val_next;
    n_len       <= n_len_next;
    idx         <= idx_next;
    rbase       <= rbase_next;
    rd_oob      <= rd_oob_next;
    status      <= e_status;
    out_byte    <= e_byte;
    byte_valid  <= e_bv;
    last_result <= e_last;
    is_empty    <= (top_next >= top_empty);
    fits        <= vrbs_pkg::fits_fn(top_next, len_src);
  end

endmodule

// ===== rtl/core/variable_record_byte_stack.sv =====
// Top level of the length-prefixed byte stack: sequencer, stack memory and checks.
// Push bytes: one item per cycle; a rejected run reports in the cycle after its last byte.
// Push commit: header written one byte a cycle (S_HWR), then the result is registered.
// Pop/peek: header read (S_HRD) and length compare (S_CALC), then one byte per cycle
// from S_DRD; busy until the final byte.
// Clear, query, empty pop/peek: result in the next cycle. Results cannot be stalled.
// Reset empties the stack and closes any push run; memory contents are not cleared.
module variable_record_byte_stack (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic [7:0]                  data_byte,
  input  logic [vrbs_pkg::LEN_W-1:0]  item_len,
  input  logic                        last,
  output logic                        valid,
  output logic [1:0]                  status,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        last_result,
  output logic                        is_empty,
  output logic                        fits
);

  vrbs_pkg::mem_req_t mreq;
  logic [7:0]         rdata;

  vrbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .item_len    (item_len),
    .last        (last),
    .mreq        (mreq),
    .rdata       (rdata),
    .valid       (valid),
    .status      (status),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_result (last_result),
    .is_empty    (is_empty),
    .fits        (fits)
  );

  vrbs_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    valid && byte_valid |-> status == vrbs_pkg::ST_OK)
    else $error("record byte with non-ok status");

  a_burst_contig: assert property (@(posedge clk) disable iff (rst)
    valid && !last_result |=> valid)
    else $error("gap inside a pop/peek byte burst");

  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last_result |-> busy)
    else $error("idle while a byte burst is unfinished");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == vrbs_pkg::REQ_CLEAR |=> valid && is_empty && last_result)
    else $error("clear did not report an empty stack");

endmodule

// ===== tb/tb_variable_record_byte_stack.sv =====
// Self-checking testbench for the length-prefixed record byte stack.
`timescale 1ns / 100ps

module tb_variable_record_byte_stack;

  localparam int RUN_LIMIT    = 200000;
  localparam int RANDOM_ITEMS = 96;
  localparam int TAIL_CYCLES  = 80;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_result;
    logic       is_empty;
    logic       fits;
  } result_t;

  class stack_tracker;
    logic [7:0]  mem_bytes [vrbs_pkg::STACK_BYTES];
    bit          written [vrbs_pkg::STACK_BYTES];
    int unsigned top_ofs = vrbs_pkg::STACK_BYTES;
    bit          run_open;
    bit          run_reject;
    int unsigned run_base;
    int unsigned run_idx;
    int unsigned run_len;
    result_t     pending [$];
    int unsigned errors;

    function bit room_for(int unsigned len);
      return (len <= vrbs_pkg::MAX_RECORD_BYTES) &&
             (top_ofs >= len + vrbs_pkg::HEADER_BYTES);
    endfunction

    function void store(int unsigned addr, logic [7:0] val);
      if (addr < vrbs_pkg::STACK_BYTES) begin
        mem_bytes[addr] = val;
        written[addr] = 1'b1;
      end
    endfunction

    function logic [7:0] fetch(int unsigned addr);
      return (addr < vrbs_pkg::STACK_BYTES) ? mem_bytes[addr] : 8'h00;
    endfunction

    function logic [63:0] top_header();
      logic [63:0] val;
      val = '0;
      for (int k = 0; k < vrbs_pkg::HEADER_BYTES; k++) begin
        val = val | (64'(fetch(top_ofs + k)) << (8 * k));
      end
      return val;
    endfunction

    function void post(logic [1:0] st, logic [7:0] b, bit bv, bit lr, int unsigned len);
      result_t r;
      r.status = st;
      r.out_byte = b;
      r.byte_valid = bv;
      r.last_result = lr;
      r.is_empty = (top_ofs >= vrbs_pkg::STACK_BYTES);
      r.fits = room_for(len);
      pending.push_back(r);
    endfunction

    // Largest requested length for pop or peek that reads only written bytes.
    function int unsigned safe_read_len();
      logic [63:0] stored;
      int unsigned lim;
      int unsigned cnt;
      int unsigned addr;
      if (top_ofs >= vrbs_pkg::STACK_BYTES) return vrbs_pkg::MAX_RECORD_BYTES;
      stored = top_header();
      lim = (stored < vrbs_pkg::MAX_RECORD_BYTES) ? stored[31:0] :
            vrbs_pkg::MAX_RECORD_BYTES;
      cnt = 0;
      addr = top_ofs + vrbs_pkg::HEADER_BYTES;
      while (cnt < lim && (addr + cnt >= vrbs_pkg::STACK_BYTES || written[addr + cnt])) cnt++;
      return (cnt == lim) ? vrbs_pkg::MAX_RECORD_BYTES : cnt;
    endfunction

    function void note_request(logic [2:0] req, logic [7:0] dat,
                               logic [vrbs_pkg::LEN_W-1:0] len, bit lst);
      logic [63:0] stored;
      logic [63:0] new_top;
      int unsigned n;
      int unsigned base;
      int unsigned hdr;
      if (req == vrbs_pkg::REQ_PUSH) begin
        if (!run_open) begin
          run_open = 1'b1;
          run_idx = 0;
          run_len = len;
          run_reject = !room_for(len);
          run_base = run_reject ? 0 : top_ofs - len;
        end
        if (!run_reject && run_idx < run_len) store(run_base + run_idx, dat);
        if (run_idx < 127) run_idx++;
        if (!lst) return;
        run_open = 1'b0;
        if (run_reject) begin
          run_reject = 1'b0;
          post(vrbs_pkg::ST_FULL, 8'h00, 1'b0, 1'b1, len);
          return;
        end
        hdr = run_base - vrbs_pkg::HEADER_BYTES;
        for (int k = 0; k < vrbs_pkg::HEADER_BYTES; k++) begin
          store(hdr + k, 8'((run_len >> (8 * k)) & 32'hFF));
        end
        top_ofs = hdr;
        post(vrbs_pkg::ST_OK, 8'h00, 1'b0, 1'b1, len);
        return;
      end
      run_open = 1'b0;
      run_reject = 1'b0;
      case (req)
        vrbs_pkg::REQ_POP, vrbs_pkg::REQ_PEEK: begin
          if (top_ofs >= vrbs_pkg::STACK_BYTES) begin
            post(vrbs_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1, len);
            return;
          end
          stored = top_header();
          n = (stored < 64'(len)) ? stored[31:0] : len;
          if (n > vrbs_pkg::MAX_RECORD_BYTES) n = vrbs_pkg::MAX_RECORD_BYTES;
          base = top_ofs + vrbs_pkg::HEADER_BYTES;
          if (req == vrbs_pkg::REQ_POP) begin
            new_top = 64'(base) + stored;
            top_ofs = (new_top > vrbs_pkg::STACK_BYTES) ? vrbs_pkg::STACK_BYTES :
                      new_top[31:0];
          end
          if (n == 0) begin
            post(vrbs_pkg::ST_OK, 8'h00, 1'b0, 1'b1, len);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              post(vrbs_pkg::ST_OK, fetch(base + i), 1'b1, (i + 1 == n), len);
            end
          end
        end
        vrbs_pkg::REQ_CLEAR: begin
          top_ofs = vrbs_pkg::STACK_BYTES;
          post(vrbs_pkg::ST_OK, 8'h00, 1'b0, 1'b1, len);
        end
        default: begin
          post(vrbs_pkg::ST_OK, 8'h00, 1'b0, 1'b1, len);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: status %0d byte %02h bv %0b last %0b empty %0b fits %0b",
                   got.status, got.out_byte, got.byte_valid, got.last_result, got.is_empty,
                   got.fits);
        end
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.out_byte !== want.out_byte ||
          got.byte_valid !== want.byte_valid || got.last_result !== want.last_result ||
          got.is_empty !== want.is_empty || got.fits !== want.fits) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (exp/act): status %0d/%0d byte %02h/%02h bv %0b/%0b",
                   want.status, got.status, want.out_byte, got.out_byte,
                   want.byte_valid, got.byte_valid);
          $display("  last %0b/%0b empty %0b/%0b fits %0b/%0b",
                   want.last_result, got.last_result, want.is_empty, got.is_empty,
                   want.fits, got.fits);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [2:0]                 req_type = vrbs_pkg::REQ_QUERY;
  logic [7:0]                 data_byte = 8'h00;
  logic [vrbs_pkg::LEN_W-1:0] item_len = '0;
  logic                       last = 1'b0;
  logic                       valid;
  logic [1:0]                 status;
  logic [7:0]                 out_byte;
  logic                       byte_valid;
  logic                       last_result;
  logic                       is_empty;
  logic                       fits;

  stack_tracker tracker = new;
  int unsigned  sent_items;
  bit           gaps_on = 1'b1;

  variable_record_byte_stack u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .item_len    (item_len),
    .last        (last),
    .valid       (valid),
    .status      (status),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_result (last_result),
    .is_empty    (is_empty),
    .fits        (fits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("FAIL variable_record_byte_stack");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && valid === 1'b1) begin
      tracker.check_result({status, out_byte, byte_valid, last_result, is_empty, fits});
    end
  end

  task automatic send(input logic [2:0] rq, input logic [7:0] db,
                      input logic [vrbs_pkg::LEN_W-1:0] ln, input bit ls);
    int unsigned gap;
    req_type <= rq;
    data_byte <= db;
    item_len <= ln;
    last <= ls;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(rq, db, ln, ls);
    sent_items++;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_run(input int unsigned len, input int unsigned count, input bit closed);
    int unsigned ln;
    for (int unsigned i = 0; i < count; i++) begin
      ln = len;
      if (i > 0 && $urandom_range(0, 3) == 0) ln = $urandom_range(0, vrbs_pkg::MAX_RECORD_BYTES);
      send(vrbs_pkg::REQ_PUSH, 8'($urandom_range(0, 255)), vrbs_pkg::LEN_W'(ln),
           closed && (i + 1 == count));
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return vrbs_pkg::MAX_RECORD_BYTES;
    if (r < 12) return $urandom_range(0, 8);
    return $urandom_range(9, vrbs_pkg::MAX_RECORD_BYTES - 1);
  endfunction

  task automatic read_top(input logic [2:0] rq);
    int unsigned lim;
    lim = tracker.safe_read_len();
    send(rq, 8'($urandom_range(0, 255)), vrbs_pkg::LEN_W'($urandom_range(0, lim)), 1'b0);
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned pick;
    int unsigned len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(vrbs_pkg::REQ_POP, 8'h00, 7'd0, 1'b0);
    send(vrbs_pkg::REQ_PEEK, 8'hFF, 7'd64, 1'b1);
    send(vrbs_pkg::REQ_QUERY, 8'h00, 7'd0, 1'b0);
    send(vrbs_pkg::REQ_QUERY, 8'h00, 7'd64, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h3C, 7'd0, 1'b1);
    send(vrbs_pkg::REQ_POP, 8'h00, 7'd64, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h00, 7'd3, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'hFF, 7'd3, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'hA5, 7'd3, 1'b1);
    send(vrbs_pkg::REQ_PEEK, 8'h00, 7'd0, 1'b0);
    send(vrbs_pkg::REQ_PEEK, 8'h00, 7'd64, 1'b0);
    send(vrbs_pkg::REQ_PEEK, 8'h00, 7'd2, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h11, 7'd2, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h22, 7'd2, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h33, 7'd2, 1'b1);
    send(vrbs_pkg::REQ_PUSH, 8'h5A, 7'd5, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'hC3, 7'd5, 1'b1);
    send(vrbs_pkg::REQ_PEEK, 8'h00, 7'd2, 1'b0);
    send(vrbs_pkg::REQ_PUSH, 8'h77, 7'd6, 1'b0);
    send(vrbs_pkg::REQ_QUERY, 8'h00, 7'd7, 1'b0);
    send(vrbs_pkg::REQ_POP, 8'h00, 7'd1, 1'b0);
    send(vrbs_pkg::REQ_POP, 8'h00, 7'd64, 1'b0);
    send(vrbs_pkg::REQ_CLEAR, 8'h00, 7'd0, 1'b0);
    send(vrbs_pkg::REQ_POP, 8'h00, 7'd5, 1'b0);

    rand_base = sent_items;
    while (sent_items - rand_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) gaps_on = $urandom_range(0, 1);
      if (sent_items - rand_base >= RANDOM_ITEMS * 3 / 4) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      len = pick_len();
      if (pick < 40) begin
        push_run(len, (len == 0) ? 1 : len, 1'b1);
      end else if (pick < 47) begin
        push_run(len, $urandom_range(1, (len < 8) ? 1 : len / 4), 1'b1);
      end else if (pick < 50) begin
        push_run(len, len + $urandom_range(1, 3), 1'b1);
      end else if (pick < 53) begin
        push_run(len, $urandom_range(1, (len == 0) ? 1 : len), 1'b0);
        send(vrbs_pkg::REQ_QUERY, 8'($urandom_range(0, 255)),
             vrbs_pkg::LEN_W'(pick_len()), 1'b0);
      end else if (pick < 70) begin
        read_top(vrbs_pkg::REQ_POP);
      end else if (pick < 82) begin
        read_top(vrbs_pkg::REQ_PEEK);
      end else if (pick < 92) begin
        send(vrbs_pkg::REQ_QUERY, 8'($urandom_range(0, 255)),
             vrbs_pkg::LEN_W'(pick_len()), 1'b0);
      end else if (pick < 95) begin
        send(vrbs_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)),
             vrbs_pkg::LEN_W'(pick_len()), 1'b0);
      end else if (pick < 98) begin
        while (tracker.room_for(vrbs_pkg::MAX_RECORD_BYTES)) begin
          push_run(vrbs_pkg::MAX_RECORD_BYTES, 1, 1'b1);
        end
        push_run(pick_len(), 2, 1'b1);
      end else begin
        push_run(0, 1, 1'b1);
      end
    end
    start <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS variable_record_byte_stack");
    end else begin
      $display("FAIL variable_record_byte_stack");
    end
    $finish;
  end

endmodule
